// File: src/sitb_pkg.sv
package sitb_pkg;

  localparam int DEFAULT_MAX_ENTRIES = 64;
  localparam int DEFAULT_MAX_LEN = 32;

  localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CHAR_NUL = 8'h00;

  localparam logic [2:0] STATUS_ABSORBED = 3'd0;
  localparam logic [2:0] STATUS_INSERTED = 3'd1;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd2;
  localparam logic [2:0] STATUS_NUMERIC = 3'd3;
  localparam logic [2:0] STATUS_FULL = 3'd4;
  localparam logic [2:0] STATUS_READ = 3'd5;
  localparam logic [2:0] STATUS_IGNORED = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SEARCH,
    S_COMPARE,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

  typedef struct packed {
    logic push;
    logic clear;
  } tok_ctrl_t;

  typedef struct packed {
    logic open;
    logic all_digits;
    logic overflow;
  } tok_status_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return is_digit(c) || ((c >= 8'h61) && (c <= 8'h7A)) ||
           ((c >= 8'h41) && (c <= 8'h5A)) || (c == CHAR_UNDERSCORE);
  endfunction

endpackage

// File: src/sitb_ram.sv
module sitb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/sitb_token.sv
module sitb_token #(
  parameter int MAX_LEN = sitb_pkg::DEFAULT_MAX_LEN
) (
  input  logic                     clk,
  input  logic                     rst,
  input  sitb_pkg::tok_ctrl_t      ctrl,
  input  logic [7:0]               ch,
  output sitb_pkg::tok_status_t    stat,
  output logic [MAX_LEN*8-1:0]     word
);

  localparam int LW = $clog2(MAX_LEN + 1);

  logic [LW-1:0] length;
  logic          all_digits;
  logic          overflow;

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      length     <= '0;
      all_digits <= 1'b1;
      overflow   <= 1'b0;
      word       <= '0;
    end else if (ctrl.push) begin
      if (32'(length) < MAX_LEN) begin
        for (int k = 0; k < MAX_LEN; k++) begin
          if (32'(length) == k) begin
            word[(MAX_LEN-1-k)*8 +: 8] <= ch;
          end
        end
        length <= length + LW'(1);
      end else begin
        overflow <= 1'b1;
      end
      if (!sitb_pkg::is_digit(ch)) begin
        all_digits <= 1'b0;
      end
    end
  end

  assign stat.open       = (length != '0);
  assign stat.all_digits = all_digits;
  assign stat.overflow   = overflow;

endmodule

// File: src/sorted_identifier_table_builder.sv
// Builds a sorted table of unique identifiers from a stream of text bytes.
// An item is transferred when start is high and busy is low. With mode 0 the
// byte in text_char is fed to the tokeniser; with mode 1 the byte at
// char_index of sorted entry entry_index is read back.
// Each item gives exactly one result, presented for one cycle with done high;
// the receiver cannot stall, so each result must be taken in that cycle.
// A byte that only extends a token, or any byte after the statement end,
// gives its result in the next cycle and busy stays low, so such items may
// follow at one per cycle. A read holds busy high for its S_READ state.
// A byte that ends a token that is not all digits walks the table from the
// first entry, one S_SEARCH and one S_COMPARE state per entry compared, and on
// insertion moves every greater entry one place up, one S_SHIFT_RD and one
// S_SHIFT_WR state per entry moved, through the one-row-per-cycle port of the
// table memory; busy stays high until its result is given.
// Synchronous reset empties the table and the current token and clears the
// statement end; the table memory needs no clearing pass.
module sorted_identifier_table_builder #(
  parameter int MAX_ENTRIES = sitb_pkg::DEFAULT_MAX_ENTRIES,
  parameter int MAX_LEN     = sitb_pkg::DEFAULT_MAX_LEN
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       mode,
  input  logic [7:0] text_char,
  input  logic [5:0] entry_index,
  input  logic [4:0] char_index,
  output logic       done,
  output logic [2:0] status,
  output logic [7:0] read_char,
  output logic [5:0] insert_position,
  output logic [6:0] entry_count,
  output logic       truncated,
  output logic       statement_ended
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int RW = MAX_LEN * 8;

  sitb_pkg::state_t      state, state_next;
  sitb_pkg::tok_ctrl_t   tok_ctrl;
  sitb_pkg::tok_status_t tok_stat;
  logic [RW-1:0]         word;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] dst, dst_next;
  logic          ended, ended_next;
  logic          rd_ok, rd_ok_next;
  logic [4:0]    rd_cidx, rd_cidx_next;

  logic          done_next;
  logic [2:0]    status_next;
  logic [7:0]    read_char_next;
  logic [5:0]    insert_position_next;
  logic          truncated_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  logic accept, full, term;
  logic [7:0] rd_byte;

  assign accept = start && !busy;
  assign busy   = (state != sitb_pkg::S_IDLE);
  assign full   = (32'(count) >= MAX_ENTRIES);
  assign term   = (text_char == sitb_pkg::CHAR_SEMICOLON) ||
                  (text_char == sitb_pkg::CHAR_NUL);

  sitb_token #(.MAX_LEN(MAX_LEN)) u_token (
    .clk  (clk),
    .rst  (rst),
    .ctrl (tok_ctrl),
    .ch   (text_char),
    .stat (tok_stat),
    .word (word)
  );

  sitb_ram #(.WIDTH(RW), .DEPTH(MAX_ENTRIES)) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    rd_byte = '0;
    for (int k = 0; k < MAX_LEN; k++) begin
      if (32'(rd_cidx) == k) begin
        rd_byte = rdata[(MAX_LEN-1-k)*8 +: 8];
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sitb_pkg::S_IDLE: begin
        if (accept) begin
          if (mode) begin
            state_next = sitb_pkg::S_READ;
          end else if (!ended && !sitb_pkg::is_ident(text_char) &&
                       tok_stat.open && !tok_stat.all_digits) begin
            state_next = sitb_pkg::S_SEARCH;
          end
        end
      end
      sitb_pkg::S_READ: state_next = sitb_pkg::S_IDLE;
      sitb_pkg::S_SEARCH: begin
        if (pos < count) begin
          state_next = sitb_pkg::S_COMPARE;
        end else if (full) begin
          state_next = sitb_pkg::S_IDLE;
        end else begin
          state_next = sitb_pkg::S_SHIFT_RD;
        end
      end
      sitb_pkg::S_COMPARE: begin
        if (word == rdata) begin
          state_next = sitb_pkg::S_IDLE;
        end else if (word < rdata) begin
          state_next = full ? sitb_pkg::S_IDLE : sitb_pkg::S_SHIFT_RD;
        end else begin
          state_next = sitb_pkg::S_SEARCH;
        end
      end
      sitb_pkg::S_SHIFT_RD: begin
        state_next = (dst == pos) ? sitb_pkg::S_IDLE : sitb_pkg::S_SHIFT_WR;
      end
      sitb_pkg::S_SHIFT_WR: state_next = sitb_pkg::S_SHIFT_RD;
      default: state_next = sitb_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    count_next           = count;
    pos_next             = pos;
    dst_next             = dst;
    ended_next           = ended;
    rd_ok_next           = rd_ok;
    rd_cidx_next         = rd_cidx;
    done_next            = 1'b0;
    status_next          = status;
    read_char_next       = read_char;
    insert_position_next = insert_position;
    truncated_next       = truncated;
    tok_ctrl             = '0;
    we                   = 1'b0;
    waddr                = AW'(dst);
    wdata                = rdata;
    raddr                = AW'(pos);
    case (state)
      sitb_pkg::S_IDLE: begin
        raddr = AW'(entry_index);
        if (accept) begin
          status_next          = sitb_pkg::STATUS_ABSORBED;
          read_char_next       = '0;
          insert_position_next = '0;
          truncated_next       = 1'b0;
          pos_next             = '0;
          if (mode) begin
            rd_ok_next   = (32'(entry_index) < 32'(count)) && (32'(char_index) < MAX_LEN);
            rd_cidx_next = char_index;
          end else if (ended) begin
            done_next   = 1'b1;
            status_next = sitb_pkg::STATUS_IGNORED;
          end else if (sitb_pkg::is_ident(text_char)) begin
            done_next     = 1'b1;
            tok_ctrl.push = 1'b1;
          end else begin
            ended_next = ended || term;
            if (tok_stat.open && tok_stat.all_digits) begin
              done_next      = 1'b1;
              status_next    = sitb_pkg::STATUS_NUMERIC;
              truncated_next = tok_stat.overflow;
              tok_ctrl.clear = 1'b1;
            end else if (!tok_stat.open) begin
              done_next = 1'b1;
            end
          end
        end
      end
      sitb_pkg::S_READ: begin
        done_next      = 1'b1;
        status_next    = sitb_pkg::STATUS_READ;
        read_char_next = rd_ok ? rd_byte : 8'h00;
      end
      sitb_pkg::S_SEARCH: begin
        if (!(pos < count)) begin
          if (full) begin
            done_next      = 1'b1;
            status_next    = sitb_pkg::STATUS_FULL;
            truncated_next = tok_stat.overflow;
            tok_ctrl.clear = 1'b1;
          end else begin
            dst_next = count;
          end
        end
      end
      sitb_pkg::S_COMPARE: begin
        if (word == rdata) begin
          done_next            = 1'b1;
          status_next          = sitb_pkg::STATUS_DUPLICATE;
          insert_position_next = 6'(pos);
          truncated_next       = tok_stat.overflow;
          tok_ctrl.clear       = 1'b1;
        end else if (word < rdata) begin
          if (full) begin
            done_next      = 1'b1;
            status_next    = sitb_pkg::STATUS_FULL;
            truncated_next = tok_stat.overflow;
            tok_ctrl.clear = 1'b1;
          end else begin
            dst_next = count;
          end
        end else begin
          pos_next = pos + CW'(1);
        end
      end
      sitb_pkg::S_SHIFT_RD: begin
        raddr = AW'(dst - CW'(1));
        if (dst == pos) begin
          we                   = 1'b1;
          waddr                = AW'(pos);
          wdata                = word;
          count_next           = count + CW'(1);
          done_next            = 1'b1;
          status_next          = sitb_pkg::STATUS_INSERTED;
          insert_position_next = 6'(pos);
          truncated_next       = tok_stat.overflow;
          tok_ctrl.clear       = 1'b1;
        end
      end
      sitb_pkg::S_SHIFT_WR: begin
        we       = 1'b1;
        dst_next = dst - CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sitb_pkg::S_IDLE;
      count <= '0;
      ended <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ended <= ended_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    pos             <= pos_next;
    dst             <= dst_next;
    rd_ok           <= rd_ok_next;
    rd_cidx         <= rd_cidx_next;
    status          <= status_next;
    read_char       <= read_char_next;
    insert_position <= insert_position_next;
    truncated       <= truncated_next;
  end

  assign entry_count     = 7'(count);
  assign statement_ended = ended;

endmodule
